// ----- sv/csfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
`timescale 1ns / 1ps

package csfd_pkg;

   // Position inside a three-byte sensor reply, one-hot coded.
   typedef enum logic [2:0] {
      POS_HIGH  = 3'b001,
      POS_LOW   = 3'b010,
      POS_CHECK = 3'b100
   } byte_pos_type;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned VALUE_W = 15;
   localparam int unsigned SCALE_W = 15;

   localparam logic [BYTE_W-1:0]  CRC_POLY    = 8'h31;
   localparam logic [WORD_W-1:0]  STATUS_MASK = 16'hFFFC;

   localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17572;
   localparam logic [SCALE_W-1:0] HUMID_SCALE = 15'd12500;
   localparam logic signed [WORD_W-1:0] TEMP_OFFSET  = -16'sd4685;
   localparam logic signed [WORD_W-1:0] HUMID_OFFSET = -16'sd600;

   // Measurement kind selected by the mode register.
   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_HUMID = 1'b1;

   // One byte through the MSB-first CRC-8, eight shift steps unrolled.
   function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/csfd_convert.sv -----
// Fixed-point conversion of a raw measurement word to centidegrees or centipercent.
`timescale 1ns / 1ps

module csfd_convert (
   input  logic [csfd_pkg::WORD_W-1:0]         word,
   input  logic                                measure_kind,
   output logic signed [csfd_pkg::VALUE_W-1:0] value
);
   import csfd_pkg::*;

   logic [WORD_W-1:0]          masked;
   logic [SCALE_W-1:0]         scale;
   logic signed [WORD_W-1:0]   offset;
   logic [WORD_W+SCALE_W-1:0]  product;
   logic signed [WORD_W-1:0]   scaled;
   logic signed [WORD_W-1:0]   sum;

   // The two status bits are dropped before scaling.
   assign masked  = word & STATUS_MASK;
   assign scale   = (measure_kind == KIND_HUMID) ? HUMID_SCALE : TEMP_SCALE;
   assign offset  = (measure_kind == KIND_HUMID) ? HUMID_OFFSET : TEMP_OFFSET;
   assign product = WORD_W'(masked) * SCALE_W'(scale);
   // Floor of product / 65536 stays below 2^15, so it is a positive 16-bit value.
   assign scaled  = signed'({1'b0, product[WORD_W+SCALE_W-1:WORD_W]});
   assign sum     = scaled + offset;
   assign value   = sum[VALUE_W-1:0];

endmodule

// ----- sv/crc8_checked_sensor_frame_decoder_unit.sv -----
// Top level of the CRC-8 checked three-byte sensor frame decoder.
`timescale 1ns / 1ps

// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------------
// request  | req_valid/req_ready | req_rx_byte, req_frame_start (one reply byte)
// response | rsp_valid/rsp_ready | rsp_raw_word, rsp_crc_good, rsp_converted_value
// csr      | csr_wr_en           | csr_wr_data (measurement kind, 0 temp, 1 humidity)
//
// One request is taken per cycle while req_ready is high. The reply state (position, CRC,
// held bytes) is updated at the edge that takes a request, and the checksum byte's result
// is written into the response register at that edge, valid in the cycle after its last byte.
// Reset is synchronous and clears the position, the CRC, the mode and the response valid.
// While a response waits unread the next request is still taken, as long as the response
// register will be emptied in the same cycle; only a stalled full response holds req_ready low.

module crc8_checked_sensor_frame_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [csfd_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [csfd_pkg::WORD_W-1:0]         rsp_raw_word,
   output logic                                rsp_crc_good,
   output logic signed [csfd_pkg::VALUE_W-1:0] rsp_converted_value,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);
   import csfd_pkg::*;

   // Reply tracking state.
   byte_pos_type        pos_ff, pos_in, pos_eff;
   logic [BYTE_W-1:0]   crc_ff, crc_in, crc_eff;
   logic [BYTE_W-1:0]   high_ff, high_in;
   logic [BYTE_W-1:0]   low_ff, low_in;
   logic                kind_ff, kind_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]           raw_ff, raw_in;
   logic                        good_ff, good_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;

   logic                        accept;
   logic                        finish;
   logic                        crc_match;
   logic [WORD_W-1:0]           word;
   logic signed [VALUE_W-1:0]   conv_value;

   // A request can be taken whenever the response register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // A start marker restarts the reply before the byte is used.
   assign pos_eff = req_frame_start ? POS_HIGH : pos_ff;
   assign crc_eff = req_frame_start ? '0 : crc_ff;

   assign word      = {high_ff, low_ff};
   assign crc_match = (crc_ff == req_rx_byte);
   assign finish    = accept && (pos_eff == POS_CHECK);

   csfd_convert u_convert (
      .word         (word),
      .measure_kind (kind_ff),
      .value        (conv_value)
   );

   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      high_in = high_ff;
      low_in  = low_ff;
      if (accept) begin
         case (pos_eff)
            POS_LOW: begin
               low_in = req_rx_byte;
               crc_in = crc_feed(crc_eff, req_rx_byte);
               pos_in = POS_CHECK;
            end
            POS_CHECK: begin
               // The checksum byte closes the reply; the next byte starts a new one.
               crc_in = '0;
               pos_in = POS_HIGH;
            end
            default: begin
               // The high byte always starts from a cleared CRC.
               high_in = req_rx_byte;
               crc_in  = crc_feed('0, req_rx_byte);
               pos_in  = POS_LOW;
            end
         endcase
      end
   end

   always_comb begin
      kind_in = csr_wr_en ? csr_wr_data : kind_ff;
   end

   // A failed checksum reports a zero word and a zero value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      raw_in       = raw_ff;
      good_in      = good_ff;
      value_in     = value_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         good_in      = crc_match;
         raw_in       = crc_match ? word : '0;
         value_in     = crc_match ? conv_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HIGH;
         crc_ff       <= '0;
         kind_ff      <= KIND_TEMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff  <= high_in;
      low_ff   <= low_in;
      raw_ff   <= raw_in;
      good_ff  <= good_in;
      value_ff <= value_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_raw_word        = raw_ff;
   assign rsp_crc_good        = good_ff;
   assign rsp_converted_value = value_ff;

   // A checksum byte always produces a pending response in the next cycle.
   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("checksum byte did not produce a response");

   // After a reply closes, the CRC is cleared and the position is back at the high byte.
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish |=> (crc_ff == '0) && (pos_ff == POS_HIGH))
      else $error("reply state not cleared after checksum byte");

   // A taken high byte always moves on to the low byte.
   a_high_to_low: assert property (@(posedge clock) disable iff (reset)
      accept && (pos_eff == POS_HIGH) |=> (pos_ff == POS_LOW))
      else $error("high byte did not advance to low byte");

   // A bad checksum never leaks the word or the value.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !good_ff |-> (raw_ff == '0) && (value_ff == '0))
      else $error("failed reply reported nonzero payload");

   // Without a checksum byte, a response is only there if it was already waiting.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !finish && !(rsp_valid_ff && !rsp_ready) |=> !rsp_valid_ff)
      else $error("response appeared without a checksum byte");

endmodule

// ----- verif/crc8_checked_sensor_frame_decoder_unit_tb.sv -----
// Self-checking testbench for the CRC-8 checked sensor frame decoder.
`timescale 1ns / 1ps

module crc8_checked_sensor_frame_decoder_unit_tb;
   import csfd_pkg::*;

   // One decoded sensor reading as it leaves the block.
   typedef struct packed {
      logic [WORD_W-1:0]  raw_word;
      logic               crc_good;
      logic [VALUE_W-1:0] value;
   } reading_type;

   // Tracks the reply state the block should be in and keeps the readings it owes.
   // take_byte() is called for every accepted request, check_reading() for every
   // accepted response.
   class reading_scoreboard;
      logic               kind = KIND_TEMP;
      logic [BYTE_W-1:0]  crc_run = '0;
      byte_pos_type       pos = POS_HIGH;
      logic [BYTE_W-1:0]  high_byte = '0;
      logic [BYTE_W-1:0]  low_byte = '0;
      reading_type        pending_readings[$];
      int                 errors = 0;

      // MSB-first CRC-8 over one byte, polynomial x^8 + x^5 + x^4 + 1.
      static function logic [BYTE_W-1:0] crc_step(logic [BYTE_W-1:0] crc,
                                                  logic [BYTE_W-1:0] b);
         logic [BYTE_W-1:0] r;
         r = crc ^ b;
         repeat (8) r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
         return r;
      endfunction

      // Clears the two status bits, then scales to centidegrees or centipercent.
      function logic [VALUE_W-1:0] scale_reading(logic [WORD_W-1:0] word);
         logic [31:0] s;
         int          v;
         s = 32'(word & STATUS_MASK);
         if (kind == KIND_HUMID) begin
            v = int'(HUMID_OFFSET) + int'((32'(HUMID_SCALE) * s) >> 16);
         end else begin
            v = int'(TEMP_OFFSET) + int'((32'(TEMP_SCALE) * s) >> 16);
         end
         return v[VALUE_W-1:0];
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b, logic start);
         reading_type r;
         // A start flag drops any partial reply before the byte is taken.
         if (start) begin
            pos = POS_HIGH;
            crc_run = '0;
         end
         case (pos)
            POS_HIGH: begin
               high_byte = b;
               crc_run = crc_step(crc_run, b);
               pos = POS_LOW;
            end
            POS_LOW: begin
               low_byte = b;
               crc_run = crc_step(crc_run, b);
               pos = POS_CHECK;
            end
            default: begin
               if (crc_run == b) begin
                  r.raw_word = {high_byte, low_byte};
                  r.crc_good = 1'b1;
                  r.value = scale_reading({high_byte, low_byte});
               end else begin
                  r = '0;
               end
               pending_readings.push_back(r);
               pos = POS_HIGH;
               crc_run = '0;
            end
         endcase
      endfunction

      function void check_reading(logic [WORD_W-1:0] raw, logic good,
                                  logic [VALUE_W-1:0] value);
         reading_type e;
         if (pending_readings.size() == 0) begin
            $display("%0t: response with no reading pending: raw %h good %b value %0d",
                     $time, raw, good, $signed(value));
            errors++;
            return;
         end
         e = pending_readings.pop_front();
         if (raw !== e.raw_word) begin
            $display("%0t: raw_word expected %h actual %h", $time, e.raw_word, raw);
            errors++;
         end
         if (good !== e.crc_good) begin
            $display("%0t: crc_good expected %b actual %b", $time, e.crc_good, good);
            errors++;
         end
         if (value !== e.value) begin
            $display("%0t: converted_value expected %0d actual %0d", $time,
                     $signed(e.value), $signed(value));
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_raw_word;
   logic                rsp_crc_good;
   logic signed [VALUE_W-1:0] rsp_converted_value;
   logic                csr_wr_en = 1'b0;
   logic                csr_wr_data = 1'b0;

   reading_scoreboard   readings = new;

   // When calm is set neither side idles; holdoff_left makes the receiver refuse
   // responses for that many cycles so the block backs up into the request side.
   bit                  calm = 1'b0;
   int                  holdoff_left = 0;
   bit                  offering = 1'b0;
   int                  bytes_sent = 0;

   crc8_checked_sensor_frame_decoder_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_raw_word        (rsp_raw_word),
      .rsp_crc_good        (rsp_crc_good),
      .rsp_converted_value (rsp_converted_value),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block wedges and a request or a reading never completes.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side. Outside a hold-off it refuses about one cycle in six, unless the
   // calm stretch is on. All values are read at the edge, before this edge's updates.
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 17);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         readings.check_reading(rsp_raw_word, rsp_crc_good, rsp_converted_value);
      end
   end

   // Offers one byte and holds it until the request is taken. Valid stays high into
   // the next call unless a random gap is inserted here; each further idle cycle
   // follows with the same odds, so about one cycle in six is left empty.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= start;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      readings.take_byte(b, start);
      bytes_sent++;
      if (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 17);
      end
   endtask

   // A full three-byte reply; a nonzero spoil value corrupts the checksum byte.
   task automatic send_reply(input logic [WORD_W-1:0] word, input logic start,
                             input logic [BYTE_W-1:0] spoil);
      logic [BYTE_W-1:0] crc;
      crc = reading_scoreboard::crc_step(8'h00, word[15:8]);
      crc = reading_scoreboard::crc_step(crc, word[7:0]);
      send_byte(word[15:8], start);
      send_byte(word[7:0], 1'b0);
      send_byte(crc ^ spoil, 1'b0);
   endtask

   // Stops offering requests and waits until every owed reading has been seen,
   // then waits on so that a late or spurious response would still show up.
   task automatic settle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (readings.pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mode register write; only called while the block is idle.
   task automatic write_kind(input logic k);
      csr_wr_en <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      readings.kind = k;
   endtask

   initial begin
      logic [WORD_W-1:0] word;
      logic              start;
      logic [BYTE_W-1:0] spoil;
      int                phase_end;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, temperature mode: both ends of the word range, back-to-back
      // replies with no start flag, a checksum failure, a start flag on the low byte
      // and one on the checksum byte.
      write_kind(KIND_TEMP);
      send_reply(16'h0000, 1'b1, 8'h00);
      send_reply(16'hFFFF, 1'b0, 8'h00);
      send_reply(16'h6614, 1'b1, 8'h5A);
      send_byte(8'hAB, 1'b1);
      send_reply(16'h0003, 1'b1, 8'h00);
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_reply(16'hFFFC, 1'b1, 8'h00);
      settle();

      // Directed part, humidity mode.
      write_kind(KIND_HUMID);
      send_reply(16'h0000, 1'b1, 8'h00);
      send_reply(16'hFFFF, 1'b0, 8'h00);
      send_reply(16'h7FFF, 1'b0, 8'h00);

      // Random part in four phases with alternating modes. Each phase boundary is a
      // pause until every reading is in. Phase 1 opens with a long receiver hold-off,
      // phase 2 runs with no idling on either side.
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_kind((ph % 2 == 0) ? KIND_TEMP : KIND_HUMID);
         calm = (ph == 2);
         if (ph == 1) holdoff_left = 80;
         phase_end = bytes_sent + 225;
         while (bytes_sent < phase_end) begin
            if ($urandom_range(99) < 80) begin
               case ($urandom_range(9))
                  0:       word = 16'h0000;
                  1:       word = 16'hFFFF;
                  2:       word = 16'h0003;
                  3:       word = 16'hFFFC;
                  default: word = 16'($urandom);
               endcase
               // Without a start flag a reply only lines up when no partial one is open.
               start = (readings.pos != POS_HIGH) ? 1'b1 : 1'($urandom_range(1));
               spoil = ($urandom_range(99) < 20) ? 8'($urandom_range(255, 1)) : 8'h00;
               send_reply(word, start, spoil);
            end else begin
               // Noise: loose bytes with random start flags, which may cut replies short.
               repeat ($urandom_range(4, 1)) begin
                  send_byte(8'($urandom), 1'($urandom_range(1)));
               end
            end
         end
      end
      calm = 1'b0;
      settle();

      if (readings.errors == 0 && readings.pending_readings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
